>>> design/dat_pkg.sv
`default_nettype none
package dat_pkg;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [4:0] REG_TMR_RELOAD_LO = 5'd0;
  localparam logic [4:0] REG_TMR_RELOAD_HI = 5'd1;
  localparam logic [4:0] REG_TMR_CTRL      = 5'd2;
  localparam logic [4:0] REG_IO_ENABLE     = 5'd3;
  localparam logic [4:0] REG_WRITE_DATA    = 5'd4;
  localparam logic [4:0] REG_DISK_CTRL     = 5'd5;
  localparam logic [4:0] REG_EXT_OUT       = 5'd6;
  localparam logic [4:0] REG_STATUS        = 5'd16;
  localparam logic [4:0] REG_READ_DATA     = 5'd17;
  localparam logic [4:0] REG_DRIVE_STATUS  = 5'd18;
  localparam logic [4:0] REG_EXT_IN        = 5'd19;

  localparam logic [1:0] CFG_SIDE_LENGTH  = 2'd0;
  localparam logic [1:0] CFG_HEAD_DELAY   = 2'd1;
  localparam logic [1:0] CFG_BYTE_PERIOD  = 2'd2;

  localparam logic [15:0] SIDE_LENGTH_RST = 16'd65500;
  localparam logic [15:0] HEAD_DELAY_RST  = 16'd50000;
  localparam logic [15:0] BYTE_PERIOD_RST = 16'd150;

  localparam logic [15:0] CRC_POLY     = 16'h8408;
  localparam logic [15:0] CRC_TOP_BIT  = 16'h8000;
  localparam logic [7:0]  STATUS_BUS_MASK = 8'h2C;
  localparam logic [7:0]  DRIVE_BUS_MASK  = 8'hF8;

  // engine flag bit positions
  localparam int EF_EOH     = 0;
  localparam int EF_SCAN    = 1;
  localparam int EF_GAP     = 2;
  localparam int EF_PREVCRC = 3;
  localparam int EF_TC      = 4;

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] reg_index;
    logic [7:0] wdata;
    logic       disk_present;
    logic [7:0] disk_byte;
    logic [7:0] open_bus;
  } dat_item_t;

  typedef struct packed {
    logic [7:0]  rdata;
    logic        irq_timer;
    logic        irq_disk;
    logic        disk_write_valid;
    logic [7:0]  disk_write_data;
    logic [15:0] disk_write_pos;
    logic [15:0] head_pos;
    logic        mirror_horizontal;
  } dat_result_t;

  typedef struct packed {
    logic disk_en;
    logic irq;
    logic irq_nxt;
  } dat_tmr_status_t;

  // reflected crc, lsb first, one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] v);
    logic [15:0] a;
    logic        carry;
    a = c;
    for (int i = 0; i < 8; i++) begin
      carry = a[0];
      a = a >> 1;
      if (carry) a = a ^ CRC_POLY;
      if (v[i]) a = a ^ CRC_TOP_BIT;
    end
    return a;
  endfunction

endpackage
`default_nettype wire

>>> design/dat_in_if.sv
`default_nettype none
interface dat_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [4:0] reg_index;
  logic [7:0] wdata;
  logic       disk_present;
  logic [7:0] disk_byte;
  logic [7:0] open_bus;

  modport source (output valid, kind, reg_index, wdata, disk_present, disk_byte,
                  open_bus, input ready);
  modport sink (input valid, kind, reg_index, wdata, disk_present, disk_byte,
                open_bus, output ready);
endinterface
`default_nettype wire

>>> design/dat_out_if.sv
`default_nettype none
interface dat_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  rdata;
  logic        irq_timer;
  logic        irq_disk;
  logic        disk_write_valid;
  logic [7:0]  disk_write_data;
  logic [15:0] disk_write_pos;
  logic [15:0] head_pos;
  logic        mirror_horizontal;

  modport source (output valid, rdata, irq_timer, irq_disk, disk_write_valid,
                  disk_write_data, disk_write_pos, head_pos, mirror_horizontal,
                  input ready);
  modport sink (input valid, rdata, irq_timer, irq_disk, disk_write_valid,
                disk_write_data, disk_write_pos, head_pos, mirror_horizontal,
                output ready);
endinterface
`default_nettype wire

>>> design/dat_timer.sv
`default_nettype none
module dat_timer import dat_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      fire,
  input  wire dat_item_t item,
  output dat_tmr_status_t status
);

  logic [15:0] reload_r, reload_nxt;
  logic [15:0] count_r, count_nxt;
  logic [1:0]  flags_r, flags_nxt;   // bit0 repeat, bit1 enable
  logic [1:0]  enables_r, enables_nxt;
  logic        irq_r, irq_nxt;

  always_comb begin
    reload_nxt  = reload_r;
    count_nxt   = count_r;
    flags_nxt   = flags_r;
    enables_nxt = enables_r;
    irq_nxt     = irq_r;
    if (fire) begin
      case (item.kind)
        KIND_TICK: begin
          if (flags_r[1]) begin
            if (count_r == 16'd0) begin
              irq_nxt   = 1'b1;
              count_nxt = reload_r;
              if (!flags_r[0]) flags_nxt[1] = 1'b0;
            end else begin
              count_nxt = count_r - 16'd1;
            end
          end
        end
        KIND_WRITE: begin
          case (item.reg_index)
            REG_TMR_RELOAD_LO: reload_nxt[7:0] = item.wdata;
            REG_TMR_RELOAD_HI: reload_nxt[15:8] = item.wdata;
            REG_TMR_CTRL: begin
              flags_nxt = {item.wdata[1] & enables_r[0], item.wdata[0]};
              if (flags_nxt[1]) count_nxt = reload_r;
              else irq_nxt = 1'b0;
            end
            REG_IO_ENABLE: begin
              enables_nxt = item.wdata[1:0];
              if (!item.wdata[0]) begin
                flags_nxt[1] = 1'b0;
                irq_nxt      = 1'b0;
              end
            end
            default: ;
          endcase
        end
        KIND_READ: begin
          // status read acknowledges both interrupts
          if (enables_r[0] && item.reg_index == REG_STATUS) irq_nxt = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reload_r  <= '0;
      count_r   <= '0;
      flags_r   <= '0;
      enables_r <= '0;
      irq_r     <= 1'b0;
    end else begin
      reload_r  <= reload_nxt;
      count_r   <= count_nxt;
      flags_r   <= flags_nxt;
      enables_r <= enables_nxt;
      irq_r     <= irq_nxt;
    end
  end

  assign status.disk_en = enables_r[0];
  assign status.irq     = irq_r;
  assign status.irq_nxt = irq_nxt;

endmodule
`default_nettype wire

>>> design/dat_engine.sv
`default_nettype none
module dat_engine import dat_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_we,
  input  wire logic [1:0]      cfg_index,
  input  wire logic [15:0]     cfg_wdata,
  input  wire logic            fire,
  input  wire dat_item_t       item,
  input  wire dat_tmr_status_t tmr,
  output dat_result_t          result
);

  logic [15:0] side_len_r, head_delay_r, byte_period_r;

  logic [7:0]  wlatch_r, wlatch_nxt;
  logic [7:0]  ctrl_r, ctrl_nxt;
  logic [7:0]  ext_r, ext_nxt;
  logic [7:0]  rlatch_r, rlatch_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [15:0] delay_r, delay_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [4:0]  ef_r, ef_nxt;
  logic        irq_r, irq_nxt;

  logic        need_irq;
  logic [7:0]  data;
  logic [15:0] crc_tail;
  logic [16:0] pos_inc;
  logic [7:0]  rdata;
  logic        wvalid;
  logic [7:0]  wdat;
  logic [15:0] wpos;

  always_comb begin
    wlatch_nxt = wlatch_r;
    ctrl_nxt   = ctrl_r;
    ext_nxt    = ext_r;
    rlatch_nxt = rlatch_r;
    pos_nxt    = pos_r;
    delay_nxt  = delay_r;
    crc_nxt    = crc_r;
    ef_nxt     = ef_r;
    irq_nxt    = irq_r;
    need_irq   = ctrl_r[7];
    data       = 8'd0;
    crc_tail   = crc_r;
    pos_inc    = {1'b0, pos_r} + 17'd1;
    rdata      = 8'd0;
    wvalid     = 1'b0;
    wdat       = 8'd0;
    wpos       = 16'd0;
    if (fire) begin
      case (item.kind)
        KIND_TICK: begin
          if (!item.disk_present || !ctrl_r[0]) begin
            ef_nxt[EF_EOH]  = 1'b1;
            ef_nxt[EF_SCAN] = 1'b0;
          end else if (ctrl_r[1] && !ef_r[EF_SCAN]) begin
            // transfer held in reset
          end else if (ef_r[EF_EOH]) begin
            delay_nxt      = head_delay_r;
            ef_nxt[EF_EOH] = 1'b0;
            ef_nxt[EF_GAP] = 1'b0;
            pos_nxt        = 16'd0;
          end else if (delay_r != 16'd0) begin
            delay_nxt = delay_r - 16'd1;
          end else begin
            ef_nxt[EF_SCAN] = 1'b1;
            if (ctrl_r[2]) begin
              data = item.disk_byte;
              if (!ef_r[EF_PREVCRC]) crc_nxt = crc_byte(crc_r, data);
              if (!ctrl_r[6]) begin
                ef_nxt[EF_GAP] = 1'b0;
                crc_nxt        = 16'd0;
              end else if (data != 8'd0 && !ef_r[EF_GAP]) begin
                ef_nxt[EF_GAP] = 1'b1;
                need_irq       = 1'b0;
              end
              if (ef_nxt[EF_GAP]) begin
                ef_nxt[EF_TC] = 1'b1;
                rlatch_nxt    = data;
                if (need_irq) irq_nxt = 1'b1;
              end
            end else begin
              if (!ctrl_r[4]) begin
                ef_nxt[EF_TC] = 1'b1;
                data          = wlatch_r;
                if (need_irq) irq_nxt = 1'b1;
              end
              if (!ctrl_r[6]) data = 8'd0;
              if (!ctrl_r[4]) begin
                crc_nxt = crc_byte(crc_r, data);
              end else begin
                // first crc byte folds in two zero bytes, then shift out low byte
                if (!ef_r[EF_PREVCRC]) crc_tail = crc_byte(crc_byte(crc_r, 8'd0), 8'd0);
                data    = crc_tail[7:0];
                crc_nxt = {8'd0, crc_tail[15:8]};
              end
              if (pos_r >= 16'd2) begin
                wvalid = 1'b1;
                wdat   = data;
                wpos   = pos_r - 16'd2;
              end
              ef_nxt[EF_GAP] = 1'b0;
            end
            ef_nxt[EF_PREVCRC] = ctrl_r[4];
            if (pos_inc >= {1'b0, side_len_r}) ctrl_nxt[0] = 1'b0;
            else delay_nxt = byte_period_r;
            pos_nxt = pos_inc[15:0];
          end
        end
        KIND_WRITE: begin
          case (item.reg_index)
            REG_IO_ENABLE: if (!item.wdata[0]) irq_nxt = 1'b0;
            REG_WRITE_DATA: if (tmr.disk_en) begin
              wlatch_nxt    = item.wdata;
              ef_nxt[EF_TC] = 1'b0;
              irq_nxt       = 1'b0;
            end
            REG_DISK_CTRL: if (tmr.disk_en) begin
              ctrl_nxt = item.wdata;
              irq_nxt  = 1'b0;
            end
            REG_EXT_OUT: if (tmr.disk_en) ext_nxt = item.wdata;
            default: ;
          endcase
        end
        KIND_READ: begin
          rdata = item.open_bus;
          if (tmr.disk_en) begin
            case (item.reg_index)
              REG_STATUS: begin
                rdata = (item.open_bus & STATUS_BUS_MASK) |
                        {6'd0, ef_r[EF_TC], tmr.irq};
                ef_nxt[EF_TC] = 1'b0;
                irq_nxt       = 1'b0;
              end
              REG_READ_DATA: begin
                ef_nxt[EF_TC] = 1'b0;
                irq_nxt       = 1'b0;
                rdata         = rlatch_r;
              end
              REG_DRIVE_STATUS: begin
                rdata = item.open_bus & DRIVE_BUS_MASK;
                if (!item.disk_present) rdata = rdata | 8'h07;
                else if (!ef_r[EF_SCAN]) rdata = rdata | 8'h02;
              end
              REG_EXT_IN: rdata = ext_r;
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_len_r    <= SIDE_LENGTH_RST;
      head_delay_r  <= HEAD_DELAY_RST;
      byte_period_r <= BYTE_PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SIDE_LENGTH: side_len_r    <= cfg_wdata;
        CFG_HEAD_DELAY:  head_delay_r  <= cfg_wdata;
        CFG_BYTE_PERIOD: byte_period_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlatch_r <= '0;
      ctrl_r   <= '0;
      ext_r    <= '0;
      rlatch_r <= '0;
      pos_r    <= '0;
      delay_r  <= '0;
      crc_r    <= '0;
      ef_r     <= 5'b00001;
      irq_r    <= 1'b0;
    end else begin
      wlatch_r <= wlatch_nxt;
      ctrl_r   <= ctrl_nxt;
      ext_r    <= ext_nxt;
      rlatch_r <= rlatch_nxt;
      pos_r    <= pos_nxt;
      delay_r  <= delay_nxt;
      crc_r    <= crc_nxt;
      ef_r     <= ef_nxt;
      irq_r    <= irq_nxt;
    end
  end

  assign result.rdata             = rdata;
  assign result.irq_timer         = tmr.irq_nxt;
  assign result.irq_disk          = irq_nxt;
  assign result.disk_write_valid  = wvalid;
  assign result.disk_write_data   = wdat;
  assign result.disk_write_pos    = wpos;
  assign result.head_pos          = pos_nxt;
  assign result.mirror_horizontal = ctrl_nxt[3];

endmodule
`default_nettype wire

>>> design/disk_adapter_transfer_and_timer_unit.sv
// disk adapter: one-shot or repeating 16-bit timer interrupt plus byte-serial disk
// transfer engine with reflected crc-16.
// in_if carries one request per cpu event: a clock tick, a register write
// or a register read, together with the disk byte under the head and the
// floating bus value. out_if returns exactly one result per request: read
// data, both interrupt levels, an optional disk byte write and the head
// position used to address the disk image.
// cfg_we/cfg_index/cfg_wdata set side length, head start delay and byte
// period; write them only while no request is in flight.
// a request accepted into the input register is processed when it fires;
// its result is then shown from the result register. one request per cycle
// is sustained while out_if.ready is high: the input register feeds the
// result register through one pass of logic; all state updates in the same cycle.
// a stalled receiver holds the result register; one more request waits in
// the input register, after which in_if.ready drops.
// reset (rst_n low, synchronous) empties both registers, restores the
// configuration defaults and clears the timer and engine state.
`default_nettype none
module disk_adapter_transfer_and_timer_unit import dat_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata,
  dat_in_if.sink           in_if,
  dat_out_if.source        out_if
);

  logic            in_valid_r;
  dat_item_t       item_r;
  logic            out_valid_r;
  dat_result_t     res_r;
  logic            fire;
  dat_tmr_status_t tmr;
  dat_result_t     res_nxt;

  assign fire        = in_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !in_valid_r || fire;

  dat_timer u_timer (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (item_r),
    .status (tmr)
  );

  dat_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .item      (item_r),
    .tmr       (tmr),
    .result    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_if.ready) in_valid_r <= in_if.valid;
      if (fire) out_valid_r <= 1'b1;
      else if (out_if.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready) begin
      item_r.kind         <= in_if.kind;
      item_r.reg_index    <= in_if.reg_index;
      item_r.wdata        <= in_if.wdata;
      item_r.disk_present <= in_if.disk_present;
      item_r.disk_byte    <= in_if.disk_byte;
      item_r.open_bus     <= in_if.open_bus;
    end
    if (fire) res_r <= res_nxt;
  end

  assign out_if.valid             = out_valid_r;
  assign out_if.rdata             = res_r.rdata;
  assign out_if.irq_timer         = res_r.irq_timer;
  assign out_if.irq_disk          = res_r.irq_disk;
  assign out_if.disk_write_valid  = res_r.disk_write_valid;
  assign out_if.disk_write_data   = res_r.disk_write_data;
  assign out_if.disk_write_pos    = res_r.disk_write_pos;
  assign out_if.head_pos          = res_r.head_pos;
  assign out_if.mirror_horizontal = res_r.mirror_horizontal;

  a_fire_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("processed request did not reach the result register");

  a_waiting_request_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !fire |=> in_valid_r && $stable(item_r))
    else $error("waiting request lost or changed");

  // a written byte lies two behind the old head, which then advances by one
  a_write_pos_tracks_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.disk_write_valid |->
      res_r.head_pos == res_r.disk_write_pos + 16'd3)
    else $error("disk write position out of step with head");

  a_no_write_fields_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r.disk_write_valid |->
      res_r.disk_write_data == 8'd0 && res_r.disk_write_pos == 16'd0)
    else $error("disk write fields set without a write");

endmodule
`default_nettype wire
